// ----- rtl/bst_pkg.sv -----
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and codes for the binary skeleton thinning core.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

	// command codes carried by the opcode field
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_THIN  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// rule bounds for the neighbour count and ring transitions
	localparam logic [3:0] NB_MIN      = 4'd2;
	localparam logic [3:0] NB_MAX      = 4'd6;
	localparam logic [3:0] RING_ONE    = 4'd1;

	// 3x3 neighbourhood around the pixel under test, ring N, NE, E, SE, S, SW, W, NW
	typedef struct packed {
		logic centre;
		logic p2;
		logic p3;
		logic p4;
		logic p5;
		logic p6;
		logic p7;
		logic p8;
		logic p9;
	} nbhd_t;

endpackage

`default_nettype wire

// ----- rtl/binary_skeleton_thinning_core.sv -----
// ----------------------------------------------------------------------------
// binary_skeleton_thinning_core
// Zhang-Suen thinning engine over a binary frame held in a bit memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: opcode, col,
//   row, pixel_in. Output channel (out_valid/out_ready) returns exactly one
//   result item per command: pixel_out, iterations, removed_count.
//   Frame size comes from the APB registers frame_width (0x0) and
//   frame_height (0x4); change them only while the core is idle.
// Timing:
//   Pixel write: result is registered in the cycle after the item is taken.
//   Pixel read: result passes the frame memory read register and S_READ.
//   Thin: each sub-iteration walks every row of the frame through the single
//   frame read port, one pixel a cycle; the command runs iterations until one
//   clears nothing. A 2-row snapshot memory keeps the original rows above the
//   current one, so the frame memory can be cleared in place.
//   One item is in flight at a time; in_ready stays low while a command works.
// Reset: control state and the size registers (256 x 256) reset; the frame
//   memory holds no defined contents until written.
// Stall: a waiting result sits in the output register; a new item is taken
//   in the same cycle the receiver takes that result.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_skeleton_thinning_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic        pixel_in,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pixel_out,
	output logic [7:0]  iterations,
	output logic [15:0] removed_count
);
	import bst_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int FRAME_DEPTH = 1 << (CW + RW);
	localparam int SNAP_DEPTH  = 2 << CW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_ROW   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;

	// ---------------- configuration registers ----------------
	logic [8:0] frame_width_q;
	logic [8:0] frame_height_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 9'd256;
			frame_height_q <= 9'd256;
		end else if (cfg_wr) begin
			if (!paddr[2]) frame_width_q <= pwdata[8:0];
			else           frame_height_q <= pwdata[8:0];
		end
	end

	assign prdata = paddr[2] ? {23'd0, frame_height_q} : {23'd0, frame_width_q};

	// clamp the size registers to the memory geometry
	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	assign w_eff = (int'(frame_width_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(frame_width_q);
	assign h_eff = (int'(frame_height_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(frame_height_q);

	// ---------------- host address decode ----------------
	logic [CW+7:0] col_x;
	logic [RW+7:0] row_x;
	logic [CW-1:0] host_col;
	logic [RW-1:0] host_row;
	logic          host_in_frame;
	logic          in_acc;

	assign col_x         = {{CW{1'b0}}, col};
	assign row_x         = {{RW{1'b0}}, row};
	assign host_col      = col_x[CW-1:0];
	assign host_row      = row_x[RW-1:0];
	assign host_in_frame = ({24'd0, col} < 32'(w_eff)) && ({24'd0, row} < 32'(h_eff));

	// ---------------- control state ----------------
	logic [2:0]    state_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] j_q;
	logic          second_q;
	logic          changed_q;
	logic [7:0]    iters_q;
	logic [15:0]   removed_q;
	logic          rd_hit_q;
	logic          out_valid_q;
	logic          pixel_out_q;
	logic [7:0]    iterations_q;
	logic [15:0]   removed_out_q;

	assign in_ready      = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_acc        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign pixel_out     = pixel_out_q;
	assign iterations    = iterations_q;
	assign removed_count = removed_out_q;

	// ---------------- walk pipeline ----------------
	logic          issue;
	logic          v_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] j_s1;
	logic          v_s2;
	logic [XW-1:0] cx_s2;
	logic [YW-1:0] cy_s2;
	logic [2:0]    win_l_s2;
	logic [2:0]    win_m_s2;
	logic [2:0]    win_r_s2;
	nbhd_t         nb;
	logic          clear_ok;
	logic          clear_now;

	assign issue = (state_q == S_ROW) && (x_q != w_eff);

	// ---------------- frame memory ----------------
	logic                 frame_mem [0:FRAME_DEPTH-1];
	logic [CW+RW-1:0]     fr_addr;
	logic [CW+RW-1:0]     fw_addr;
	logic                 fw_en;
	logic                 fw_data;
	logic                 frame_rd_q;

	assign fr_addr = issue ? {j_q[RW-1:0], x_q[CW-1:0]} : {host_row, host_col};

	always_comb begin
		fw_en   = 1'b0;
		fw_addr = {cy_s2[RW-1:0], cx_s2[CW-1:0]};
		fw_data = 1'b0;
		if (clear_now) begin
			fw_en = 1'b1;
		end else if (in_acc && opcode == OP_WRITE && host_in_frame) begin
			fw_en   = 1'b1;
			fw_addr = {host_row, host_col};
			fw_data = pixel_in;
		end
	end

	always_ff @(posedge clk) begin
		if (fw_en) frame_mem[fw_addr] <= fw_data;
		frame_rd_q <= frame_mem[fr_addr];
	end

	// ---------------- snapshot memory: two original rows ----------------
	logic snap_mem [0:SNAP_DEPTH-1];
	logic snap0_q;
	logic snap1_q;

	always_ff @(posedge clk) begin
		if (v_s1) snap_mem[{j_s1[0], x_s1[CW-1:0]}] <= frame_rd_q;
		snap0_q <= snap_mem[{1'b0, x_q[CW-1:0]}];
		snap1_q <= snap_mem[{1'b1, x_q[CW-1:0]}];
	end

	// ---------------- stage 1: build the 3x3 window ----------------
	logic top_s1;
	logic mid_s1;

	// slot of row j holds row j-2 before it is overwritten, the other slot row j-1
	assign top_s1 = j_s1[0] ? snap1_q : snap0_q;
	assign mid_s1 = j_s1[0] ? snap0_q : snap1_q;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			win_l_s2 <= win_m_s2;
			win_m_s2 <= win_r_s2;
			win_r_s2 <= {top_s1, mid_s1, frame_rd_q};
			cx_s2    <= x_s1 - XW'(1);
			cy_s2    <= j_s1 - YW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && (x_s1 >= XW'(2)) && (j_s1 >= YW'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1 <= x_q;
			j_s1 <= j_q;
		end
	end

	// ---------------- stage 2: judge the centre pixel ----------------
	assign nb.p9     = win_l_s2[2];
	assign nb.p8     = win_l_s2[1];
	assign nb.p7     = win_l_s2[0];
	assign nb.p2     = win_m_s2[2];
	assign nb.centre = win_m_s2[1];
	assign nb.p6     = win_m_s2[0];
	assign nb.p3     = win_r_s2[2];
	assign nb.p4     = win_r_s2[1];
	assign nb.p5     = win_r_s2[0];

	bst_cell u_cell (
		.nb       (nb),
		.second   (second_q),
		.clear_ok (clear_ok)
	);

	assign clear_now = v_s2 && clear_ok;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_q         <= '0;
			j_q         <= '0;
			second_q    <= 1'b0;
			changed_q   <= 1'b0;
			iters_q     <= '0;
			removed_q   <= '0;
			rd_hit_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			// count every cleared pixel, saturating
			if (clear_now) begin
				changed_q <= 1'b1;
				if (removed_q != 16'hFFFF) removed_q <= removed_q + 16'd1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (opcode)
							OP_READ: begin
								rd_hit_q <= host_in_frame;
								state_q  <= S_READ;
							end
							OP_THIN: begin
								iters_q   <= 8'd1;
								removed_q <= '0;
								changed_q <= 1'b0;
								second_q  <= 1'b0;
								x_q       <= '0;
								j_q       <= '0;
								state_q   <= S_ROW;
							end
							default: begin
								// pixel write and the spare code return zeros
								out_valid_q   <= 1'b1;
								pixel_out_q   <= 1'b0;
								iterations_q  <= '0;
								removed_out_q <= '0;
							end
						endcase
					end
				end
				S_READ: begin
					out_valid_q   <= 1'b1;
					pixel_out_q   <= rd_hit_q & frame_rd_q;
					iterations_q  <= '0;
					removed_out_q <= '0;
					state_q       <= S_IDLE;
				end
				S_ROW: begin
					if (issue) x_q <= x_q + XW'(1);
					else       state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					// hold until the last clear of the row has landed
					if (!v_s1 && !v_s2) begin
						x_q <= '0;
						if (32'(j_q) + 32'd1 < 32'(h_eff)) begin
							j_q     <= j_q + YW'(1);
							state_q <= S_ROW;
						end else if (!second_q) begin
							second_q <= 1'b1;
							j_q      <= '0;
							state_q  <= S_ROW;
						end else if (changed_q) begin
							if (iters_q != 8'hFF) iters_q <= iters_q + 8'd1;
							changed_q <= 1'b0;
							second_q  <= 1'b0;
							j_q       <= '0;
							state_q   <= S_ROW;
						end else begin
							out_valid_q   <= 1'b1;
							pixel_out_q   <= 1'b0;
							iterations_q  <= iters_q;
							removed_out_q <= removed_q;
							state_q       <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bst_cell.sv -----
// ----------------------------------------------------------------------------
// bst_cell
// Thinning rule for one pixel: decides whether a set pixel is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_cell (
	input  var bst_pkg::nbhd_t nb,
	input  logic               second,
	output logic               clear_ok
);
	import bst_pkg::*;

	logic [7:0] ring;
	logic [7:0] ring_next;
	logic [3:0] set_cnt;
	logic [3:0] rise_cnt;
	logic       t1;
	logic       t2;

	assign ring      = {nb.p9, nb.p8, nb.p7, nb.p6, nb.p5, nb.p4, nb.p3, nb.p2};
	assign ring_next = {nb.p2, nb.p9, nb.p8, nb.p7, nb.p6, nb.p5, nb.p4, nb.p3};
	assign set_cnt   = 4'($countones(ring));
	assign rise_cnt  = 4'($countones(~ring & ring_next));

	always_comb begin
		if (!second) begin
			t1 = !(nb.p2 & nb.p4 & nb.p6);
			t2 = !(nb.p4 & nb.p6 & nb.p8);
		end else begin
			t1 = !(nb.p2 & nb.p4 & nb.p8);
			t2 = !(nb.p2 & nb.p6 & nb.p8);
		end
	end

	assign clear_ok = nb.centre && (set_cnt >= NB_MIN) && (set_cnt <= NB_MAX)
		&& (rise_cnt == RING_ONE) && t1 && t2;

endmodule

`default_nettype wire

// ----- rtl/bst_checker.sv -----
// ----------------------------------------------------------------------------
// bst_checker
// Port-level assertions for the binary skeleton thinning core.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic        pixel_out,
	input logic [7:0]  iterations,
	input logic [15:0] removed_count
);
	import bst_pkg::*;

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// a pixel write answers next cycle with an all-zero item
	a_write_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_WRITE |=>
		out_valid && !pixel_out && iterations == 8'd0 && removed_count == 16'd0)
		else $error("pixel write result missing or not zero");

	// a thin command blocks new items while it walks the frame
	a_thin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_THIN |=> !in_ready)
		else $error("item taken while thinning");

	// only a thin result carries counts, and it runs at least one iteration
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && iterations == 8'd0 |-> removed_count == 16'd0)
		else $error("removed count without iterations");

	a_pixel_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_out |-> iterations == 8'd0)
		else $error("pixel result mixed with thin counts");

endmodule

bind binary_skeleton_thinning_core bst_checker u_bst_checker (.*);

`default_nettype wire
